FILE: hdl/ffsm_pkg.sv
// Shared types and constants for the flex-fuel sensor monitor.
package ffsm_pkg;

    localparam int ETH_W   = 18;
    localparam int TEMP_W  = 16;
    localparam int LEVEL_W = 17;
    localparam int REG_IDX_W = 4;
    localparam int CFG_DATA_W = 18;

    // Cold-limit product: signed 17-bit slope times 18-bit signed level.
    localparam int SLOPE_W = TEMP_W + 1;
    localparam int PROD_W  = SLOPE_W + LEVEL_W + 1;

    localparam logic signed [ETH_W-1:0] ETH_FULL_SCALE = 18'sd65536;
    localparam logic [LEVEL_W-1:0]      LEVEL_FULL     = 17'h10000;
    localparam logic [LEVEL_W-1:0]      LEVEL_ZERO     = 17'h00000;

    // Queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_TEMP_WARN_HIGH  = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_CRIT_HIGH  = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_WARN_LOW   = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_TEMP_CRIT_LOW   = 4'd3;
    localparam logic [REG_IDX_W-1:0] REG_ETH_CRIT_HIGH   = 4'd4;
    localparam logic [REG_IDX_W-1:0] REG_ETH_CRIT_LOW    = 4'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLD_LIMIT_ETH  = 4'd6;
    localparam logic [REG_IDX_W-1:0] REG_COLD_LIMIT_GAS  = 4'd7;

    localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN_HIGH = 16'sd1600;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_CRIT_HIGH = 16'sd1920;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_WARN_LOW  = -16'sd320;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_CRIT_LOW  = -16'sd640;
    localparam logic signed [ETH_W-1:0]  RST_ETH_CRIT_HIGH  = 18'sd72090;
    localparam logic signed [ETH_W-1:0]  RST_ETH_CRIT_LOW   = -18'sd6554;
    localparam logic signed [TEMP_W-1:0] RST_COLD_LIMIT_ETH = 16'sd448;
    localparam logic signed [TEMP_W-1:0] RST_COLD_LIMIT_GAS = -16'sd512;

    typedef struct packed {
        logic signed [ETH_W-1:0]  raw_ethanol;
        logic signed [TEMP_W-1:0] raw_temperature;
    } sample_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]       ethanol_level;
        logic signed [TEMP_W-1:0] fuel_temperature;
        logic                     eth_warn_high_flag;
        logic                     eth_warn_low_flag;
        logic                     eth_crit_high_flag;
        logic                     eth_crit_low_flag;
        logic                     temp_warn_high_flag;
        logic                     temp_warn_low_flag;
        logic                     temp_crit_high_flag;
        logic                     temp_crit_low_flag;
        logic                     cold_start_needed;
    } result_t;

    typedef struct packed {
        logic tcl;
        logic tch;
        logic twl;
        logic twh;
        logic ecl;
        logic ech;
        logic ewl;
        logic ewh;
    } alarm_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_warn_high;
        logic signed [TEMP_W-1:0] temp_crit_high;
        logic signed [TEMP_W-1:0] temp_warn_low;
        logic signed [TEMP_W-1:0] temp_crit_low;
        logic signed [ETH_W-1:0]  eth_crit_high;
        logic signed [ETH_W-1:0]  eth_crit_low;
        logic signed [TEMP_W-1:0] cold_limit_eth;
        logic signed [TEMP_W-1:0] cold_limit_gas;
    } cfg_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic [LEVEL_W-1:0]       level;
        logic signed [TEMP_W-1:0] temp;
        alarm_t                   alarm;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: hdl/ffsm_front.sv
// Front end: accepts samples, clamps ethanol and updates the sticky alarm flags.
module ffsm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  ffsm_pkg::sample_t    sample_data,
    input  ffsm_pkg::cfg_t       cfg,
    input  ffsm_pkg::q_status_t  q_status,
    output logic                 push,
    output ffsm_pkg::q_entry_t   push_entry
);

    ffsm_pkg::alarm_t                   alarm_reg;
    ffsm_pkg::alarm_t                   alarm_next;
    logic [ffsm_pkg::LEVEL_W-1:0]       level;
    logic signed [ffsm_pkg::ETH_W-1:0]  r;
    logic signed [ffsm_pkg::TEMP_W-1:0] t;

    assign r = sample_data.raw_ethanol;
    assign t = sample_data.raw_temperature;

    assign sample_stall = q_status.full;
    assign push         = sample_valid && !q_status.full;

    always_comb
    begin
        alarm_next = alarm_reg;
        level      = r[ffsm_pkg::LEVEL_W-1:0];
        if (r > ffsm_pkg::ETH_FULL_SCALE)
        begin
            level          = ffsm_pkg::LEVEL_FULL;
            alarm_next.ewh = 1'b1;
            if (r > cfg.eth_crit_high)
                alarm_next.ech = 1'b1;
        end
        else if (r[ffsm_pkg::ETH_W-1])
        begin
            level          = ffsm_pkg::LEVEL_ZERO;
            alarm_next.ewl = 1'b1;
            if (r < cfg.eth_crit_low)
                alarm_next.ecl = 1'b1;
        end
        else
        begin
            alarm_next.ewh = 1'b0;
            alarm_next.ewl = 1'b0;
            alarm_next.ech = 1'b0;
            alarm_next.ecl = 1'b0;
        end

        if (t > cfg.temp_warn_high)
        begin
            alarm_next.twh = 1'b1;
            if (t > cfg.temp_crit_high)
                alarm_next.tch = 1'b1;
        end
        else if (t < cfg.temp_warn_low)
        begin
            alarm_next.twl = 1'b1;
            if (t < cfg.temp_crit_low)
                alarm_next.tcl = 1'b1;
        end
        else
        begin
            alarm_next.twh = 1'b0;
            alarm_next.twl = 1'b0;
            alarm_next.tch = 1'b0;
            alarm_next.tcl = 1'b0;
        end
    end

    assign push_entry.level = level;
    assign push_entry.temp  = t;
    assign push_entry.alarm = alarm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alarm_reg <= '0;
        else if (push)
            alarm_reg <= alarm_next;
    end

endmodule

FILE: hdl/ffsm_queue.sv
// Short register queue between the front and back ends.
module ffsm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ffsm_pkg::q_entry_t   push_entry,
    input  logic                 pop,
    output ffsm_pkg::q_entry_t   head,
    output ffsm_pkg::q_status_t  status
);

    ffsm_pkg::q_entry_t              entry_reg [ffsm_pkg::QDEPTH];
    logic [ffsm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ffsm_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [ffsm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ffsm_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [ffsm_pkg::QCNT_W-1:0]     count_reg;
    logic [ffsm_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign status.full  = (count_reg == ffsm_pkg::QCNT_W'(ffsm_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    // Advance a pointer, wrapping at the queue depth.
    function automatic logic [ffsm_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ffsm_pkg::QPTR_W-1:0] p
    );
        logic [ffsm_pkg::QPTR_W-1:0] n;
        begin
            if (p == ffsm_pkg::QPTR_W'(ffsm_pkg::QDEPTH - 1))
                n = '0;
            else
                n = p + 1'b1;
            return n;
        end
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: hdl/ffsm_back.sv
// Back end: cold-start limit compare in two stages and the result register.
module ffsm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ffsm_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  ffsm_pkg::q_entry_t  q_head,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output ffsm_pkg::result_t   result_data
);

    // Stage A: product of slope and level.
    logic                                a_valid_reg;
    logic                                a_valid_next;
    ffsm_pkg::q_entry_t                  a_entry_reg;
    logic signed [ffsm_pkg::PROD_W-1:0]  a_prod_reg;
    logic signed [ffsm_pkg::PROD_W-1:0]  prod_next;
    logic signed [ffsm_pkg::SLOPE_W-1:0] slope;
    logic signed [ffsm_pkg::LEVEL_W:0]   level_s;

    // Stage B: result register.
    logic                                out_valid_reg;
    logic                                out_valid_next;
    ffsm_pkg::result_t                   out_reg;
    ffsm_pkg::result_t                   out_next;
    logic signed [ffsm_pkg::SLOPE_W-1:0] t_rel;
    logic signed [ffsm_pkg::PROD_W-1:0]  lhs;

    logic a_load;
    logic b_load;

    assign b_load = !out_valid_reg || !result_stall;
    assign a_load = !a_valid_reg || b_load;
    assign q_pop  = q_valid && a_load;

    // limit*65536 = G*65536 + (E-G)*L, so compare (T-G)*65536 against (E-G)*L.
    assign slope     = {cfg.cold_limit_eth[ffsm_pkg::TEMP_W-1], cfg.cold_limit_eth}
                     - {cfg.cold_limit_gas[ffsm_pkg::TEMP_W-1], cfg.cold_limit_gas};
    assign level_s   = {1'b0, q_head.level};
    assign prod_next = slope * level_s;

    assign t_rel = {a_entry_reg.temp[ffsm_pkg::TEMP_W-1], a_entry_reg.temp}
                 - {cfg.cold_limit_gas[ffsm_pkg::TEMP_W-1], cfg.cold_limit_gas};
    assign lhs   = {{(ffsm_pkg::PROD_W - ffsm_pkg::SLOPE_W - 16){t_rel[ffsm_pkg::SLOPE_W-1]}},
                    t_rel, 16'h0000};

    always_comb
    begin
        out_next.ethanol_level       = a_entry_reg.level;
        out_next.fuel_temperature    = a_entry_reg.temp;
        out_next.eth_warn_high_flag  = a_entry_reg.alarm.ewh;
        out_next.eth_warn_low_flag   = a_entry_reg.alarm.ewl;
        out_next.eth_crit_high_flag  = a_entry_reg.alarm.ech;
        out_next.eth_crit_low_flag   = a_entry_reg.alarm.ecl;
        out_next.temp_warn_high_flag = a_entry_reg.alarm.twh;
        out_next.temp_warn_low_flag  = a_entry_reg.alarm.twl;
        out_next.temp_crit_high_flag = a_entry_reg.alarm.tch;
        out_next.temp_crit_low_flag  = a_entry_reg.alarm.tcl;
        out_next.cold_start_needed   = (lhs < a_prod_reg);
    end

    assign a_valid_next   = a_load ? q_valid : a_valid_reg;
    assign out_valid_next = b_load ? a_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_entry_reg <= q_head;
            a_prod_reg  <= prod_next;
        end
        if (b_load && a_valid_reg)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

FILE: hdl/flex_fuel_sensor_monitor.sv
// Top level of the flex-fuel sensor monitor: registers, front, queue, back.
//
// Usage:
//   Samples (raw ethanol fraction, fuel temperature) enter on the sample
//   channel; a request is taken on a rising edge with sample_valid high and
//   sample_stall low. Each sample yields exactly one result on the result
//   channel, taken on an edge with result_valid high and result_stall low.
//   Results leave in sample order.
//   From sample acceptance to result_valid a sample passes the queue
//   entry, the multiply stage register and the result register; the
//   latter then holds it. Throughput is one sample per cycle: every stage
//   takes a new request each cycle while the receiver keeps up.
//   The front end updates the sticky alarm flags as each sample is taken,
//   so flag order always follows sample order.
//   When the receiver stalls, the result register holds, the multiply
//   stage fills, and the two-entry queue absorbs two more samples; after
//   that sample_stall rises until the back end drains.
//   Configuration registers are written through cfg_we/cfg_addr/cfg_data
//   at any edge with cfg_we high; indexes beyond the register list are
//   dropped. Write them only while the block is idle.
//   Reset clears all alarm flags, empties the queue and pipeline, and
//   loads every threshold register with its default.
module flex_fuel_sensor_monitor (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  ffsm_pkg::sample_t                  sample_data,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ffsm_pkg::result_t                  result_data,
    input  logic                               cfg_we,
    input  logic [ffsm_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [ffsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ffsm_pkg::cfg_t      cfg_reg;
    ffsm_pkg::cfg_t      cfg_next;
    ffsm_pkg::q_status_t q_status;
    ffsm_pkg::q_entry_t  push_entry;
    ffsm_pkg::q_entry_t  q_head;
    logic                push;
    logic                q_pop;

    // Register file decode: pick the target register, drop unknown indexes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                ffsm_pkg::REG_TEMP_WARN_HIGH:
                    cfg_next.temp_warn_high = cfg_data[ffsm_pkg::TEMP_W-1:0];
                ffsm_pkg::REG_TEMP_CRIT_HIGH:
                    cfg_next.temp_crit_high = cfg_data[ffsm_pkg::TEMP_W-1:0];
                ffsm_pkg::REG_TEMP_WARN_LOW:
                    cfg_next.temp_warn_low  = cfg_data[ffsm_pkg::TEMP_W-1:0];
                ffsm_pkg::REG_TEMP_CRIT_LOW:
                    cfg_next.temp_crit_low  = cfg_data[ffsm_pkg::TEMP_W-1:0];
                ffsm_pkg::REG_ETH_CRIT_HIGH:
                    cfg_next.eth_crit_high  = cfg_data[ffsm_pkg::ETH_W-1:0];
                ffsm_pkg::REG_ETH_CRIT_LOW:
                    cfg_next.eth_crit_low   = cfg_data[ffsm_pkg::ETH_W-1:0];
                ffsm_pkg::REG_COLD_LIMIT_ETH:
                    cfg_next.cold_limit_eth = cfg_data[ffsm_pkg::TEMP_W-1:0];
                ffsm_pkg::REG_COLD_LIMIT_GAS:
                    cfg_next.cold_limit_gas = cfg_data[ffsm_pkg::TEMP_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_warn_high <= ffsm_pkg::RST_TEMP_WARN_HIGH;
            cfg_reg.temp_crit_high <= ffsm_pkg::RST_TEMP_CRIT_HIGH;
            cfg_reg.temp_warn_low  <= ffsm_pkg::RST_TEMP_WARN_LOW;
            cfg_reg.temp_crit_low  <= ffsm_pkg::RST_TEMP_CRIT_LOW;
            cfg_reg.eth_crit_high  <= ffsm_pkg::RST_ETH_CRIT_HIGH;
            cfg_reg.eth_crit_low   <= ffsm_pkg::RST_ETH_CRIT_LOW;
            cfg_reg.cold_limit_eth <= ffsm_pkg::RST_COLD_LIMIT_ETH;
            cfg_reg.cold_limit_gas <= ffsm_pkg::RST_COLD_LIMIT_GAS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify and stamp the sticky flags as each sample arrives.
    ffsm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Decouple the front from result-side stalls.
    ffsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // Compute cold start and hold the result until taken.
    ffsm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (!q_status.empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Stall only when the queue has no room.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == q_status.full)
        else $error("sample_stall does not track queue full");

    // Clamped level never exceeds full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.ethanol_level <= ffsm_pkg::LEVEL_FULL))
        else $error("ethanol level above full scale");

    // A critical flag is only ever raised together with its warning flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((!result_data.temp_crit_high_flag || result_data.temp_warn_high_flag) &&
             (!result_data.temp_crit_low_flag  || result_data.temp_warn_low_flag)  &&
             (!result_data.eth_crit_high_flag  || result_data.eth_warn_high_flag)  &&
             (!result_data.eth_crit_low_flag   || result_data.eth_warn_low_flag)))
        else $error("critical flag without matching warning flag");

    // Nothing pops from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
